FILE: rtl/rsws_pkg.sv
// Shared constants, codes and item types of the reservation station.
`default_nettype none
package rsws_pkg;

  localparam int Entries  = 8;
  localparam int IdxW     = $clog2(Entries);
  localparam int TagW     = 6;
  localparam int BusTagW  = 5;
  localparam int DataW    = 32;
  localparam int OpW      = 6;
  localparam int KindW    = 3;

  localparam logic [TagW-1:0]  TAG_NONE = '1;
  localparam logic [KindW-1:0] KIND_I   = 3'd1;
  localparam logic [KindW-1:0] KIND_MAX = 3'd4;

  typedef enum logic [1:0] {
    FUNC_BROADCAST = 2'd0,
    FUNC_DISPATCH  = 2'd1,
    FUNC_CYCLE     = 2'd2,
    FUNC_FLUSH     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_FULL = 2'd1,
    ERR_KIND = 2'd2
  } err_e;

  typedef struct packed {
    logic [1:0]              func;
    logic [OpW-1:0]          operation;
    logic [KindW-1:0]        kind;
    logic                    is_jump_register;
    logic [BusTagW-1:0]      dest_tag;
    logic signed [TagW-1:0]  src1_tag;
    logic signed [TagW-1:0]  src2_tag;
    logic [DataW-1:0]        src1_value;
    logic [DataW-1:0]        src2_value;
    logic [DataW-1:0]        immediate;
    logic [BusTagW-1:0]      bus_tag;
    logic [DataW-1:0]        bus_value;
  } item_t;

  typedef struct packed {
    logic                issue_valid;
    logic [OpW-1:0]      issue_operation;
    logic [BusTagW-1:0]  issue_dest;
    logic [DataW-1:0]    operand_a;
    logic [DataW-1:0]    operand_b;
    logic                station_full;
    logic [1:0]          error_code;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/rsws_if.sv
// Request and response channel interfaces of the reservation station.
`default_nettype none
interface rsws_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               func;
  logic [rsws_pkg::OpW-1:0]                 operation;
  logic [rsws_pkg::KindW-1:0]               kind;
  logic                                     is_jump_register;
  logic [rsws_pkg::BusTagW-1:0]             dest_tag;
  logic signed [rsws_pkg::TagW-1:0]         src1_tag;
  logic signed [rsws_pkg::TagW-1:0]         src2_tag;
  logic [rsws_pkg::DataW-1:0]               src1_value;
  logic [rsws_pkg::DataW-1:0]               src2_value;
  logic [rsws_pkg::DataW-1:0]               immediate;
  logic [rsws_pkg::BusTagW-1:0]             bus_tag;
  logic [rsws_pkg::DataW-1:0]               bus_value;

  modport source (
    output valid, func, operation, kind, is_jump_register, dest_tag, src1_tag, src2_tag,
           src1_value, src2_value, immediate, bus_tag, bus_value,
    input  ready
  );
  modport sink (
    input  valid, func, operation, kind, is_jump_register, dest_tag, src1_tag, src2_tag,
           src1_value, src2_value, immediate, bus_tag, bus_value,
    output ready
  );
endinterface

interface rsws_out_if;
  logic                          valid;
  logic                          ready;
  logic                          issue_valid;
  logic [rsws_pkg::OpW-1:0]      issue_operation;
  logic [rsws_pkg::BusTagW-1:0]  issue_dest;
  logic [rsws_pkg::DataW-1:0]    operand_a;
  logic [rsws_pkg::DataW-1:0]    operand_b;
  logic                          station_full;
  logic [1:0]                    error_code;

  modport source (
    output valid, issue_valid, issue_operation, issue_dest, operand_a, operand_b,
           station_full, error_code,
    input  ready
  );
  modport sink (
    input  valid, issue_valid, issue_operation, issue_dest, operand_a, operand_b,
           station_full, error_code,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/rsws_slots.sv
// Slot storage with tag wakeup, lowest-free dispatch and lowest-ready issue.
`default_nettype none
module rsws_slots (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire rsws_pkg::item_t   item_i,
  output rsws_pkg::result_t      result_o
);

  localparam int E = rsws_pkg::Entries;

  logic [E-1:0] valid_q, valid_d;
  logic [E-1:0] ready_q, ready_d;

  logic [rsws_pkg::OpW-1:0]     op_q     [E];
  logic [rsws_pkg::KindW-1:0]   kind_q   [E];
  logic                         jr_q     [E];
  logic [rsws_pkg::BusTagW-1:0] dest_q   [E];
  logic [rsws_pkg::TagW-1:0]    tag_a_q  [E];
  logic [rsws_pkg::TagW-1:0]    tag_b_q  [E];
  logic [rsws_pkg::DataW-1:0]   val_a_q  [E];
  logic [rsws_pkg::DataW-1:0]   val_b_q  [E];
  logic [rsws_pkg::DataW-1:0]   imm_q    [E];

  logic                         is_bcast, is_flush, is_disp, is_cycle;
  logic                         has_free, do_disp;
  logic [rsws_pkg::IdxW-1:0]    free_idx;
  logic [rsws_pkg::TagW-1:0]    new_tag_a, new_tag_b;
  logic                         new_ready, new_use_imm;
  logic [E-1:0]                 pre_valid, pre_ready, hit_a, hit_b;
  logic                         issue_any;
  logic [rsws_pkg::IdxW-1:0]    issue_idx;
  logic                         issue_new;
  rsws_pkg::err_e               err;

  assign is_bcast = item_i.func == rsws_pkg::FUNC_BROADCAST;
  assign is_flush = item_i.func == rsws_pkg::FUNC_FLUSH;
  assign is_disp  = item_i.func == rsws_pkg::FUNC_DISPATCH;
  assign is_cycle = is_disp || (item_i.func == rsws_pkg::FUNC_CYCLE);

  // Lowest free slot.
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = E - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = rsws_pkg::IdxW'(i);
      end
    end
  end

  assign new_use_imm = (item_i.kind == rsws_pkg::KIND_I) && !item_i.is_jump_register;
  assign new_tag_a   = $unsigned(item_i.src1_tag);
  assign new_tag_b   = new_use_imm ? rsws_pkg::TAG_NONE : $unsigned(item_i.src2_tag);
  assign new_ready   = (new_tag_a == rsws_pkg::TAG_NONE) && (new_tag_b == rsws_pkg::TAG_NONE);
  assign do_disp     = is_disp && has_free && (item_i.kind <= rsws_pkg::KIND_MAX);

  always_comb begin
    err = rsws_pkg::ERR_NONE;
    if (is_disp) begin
      if (!has_free) begin
        err = rsws_pkg::ERR_FULL;
      end else if (item_i.kind > rsws_pkg::KIND_MAX) begin
        err = rsws_pkg::ERR_KIND;
      end
    end
  end

  // Slot view after the dispatch write, which the issue select sees.
  always_comb begin
    for (int i = 0; i < E; i++) begin
      if (do_disp && (free_idx == rsws_pkg::IdxW'(i))) begin
        pre_valid[i] = 1'b1;
        pre_ready[i] = new_ready;
      end else begin
        pre_valid[i] = valid_q[i];
        pre_ready[i] = ready_q[i];
      end
      hit_a[i] = valid_q[i] && (tag_a_q[i] == {1'b0, item_i.bus_tag});
      hit_b[i] = valid_q[i] && (tag_b_q[i] == {1'b0, item_i.bus_tag});
    end
  end

  always_comb begin
    issue_any = 1'b0;
    issue_idx = '0;
    for (int i = E - 1; i >= 0; i--) begin
      if (is_cycle && pre_valid[i] && pre_ready[i]) begin
        issue_any = 1'b1;
        issue_idx = rsws_pkg::IdxW'(i);
      end
    end
  end

  assign issue_new = do_disp && (issue_idx == free_idx);

  always_comb begin
    valid_d = valid_q;
    ready_d = ready_q;
    if (is_flush) begin
      valid_d = '0;
      ready_d = '0;
    end else if (is_bcast) begin
      for (int i = 0; i < E; i++) begin
        if (valid_q[i] && (hit_a[i] || tag_a_q[i] == rsws_pkg::TAG_NONE)
            && (hit_b[i] || tag_b_q[i] == rsws_pkg::TAG_NONE)) begin
          ready_d[i] = 1'b1;
        end
      end
    end else begin
      valid_d = pre_valid;
      ready_d = pre_ready;
      if (issue_any) begin
        valid_d[issue_idx] = 1'b0;
        ready_d[issue_idx] = 1'b0;
      end
    end
  end

  always_comb begin
    result_o = '0;
    result_o.station_full = &valid_d;
    result_o.error_code   = err;
    if (issue_any) begin
      result_o.issue_valid = 1'b1;
      if (issue_new) begin
        result_o.issue_operation = item_i.operation;
        result_o.issue_dest      = item_i.dest_tag;
        result_o.operand_a       = item_i.src1_value;
        result_o.operand_b       = new_use_imm ? item_i.immediate : item_i.src2_value;
      end else begin
        result_o.issue_operation = op_q[issue_idx];
        result_o.issue_dest      = dest_q[issue_idx];
        result_o.operand_a       = val_a_q[issue_idx];
        result_o.operand_b       = ((kind_q[issue_idx] == rsws_pkg::KIND_I) && !jr_q[issue_idx])
                                   ? imm_q[issue_idx] : val_b_q[issue_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ready_q <= '0;
    end else if (step_i) begin
      valid_q <= valid_d;
      ready_q <= ready_d;
    end
  end

  // Payload fields are only read while the slot is valid, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (is_bcast) begin
        for (int i = 0; i < E; i++) begin
          if (hit_a[i]) begin
            val_a_q[i] <= item_i.bus_value;
            tag_a_q[i] <= rsws_pkg::TAG_NONE;
          end
          if (hit_b[i]) begin
            val_b_q[i] <= item_i.bus_value;
            tag_b_q[i] <= rsws_pkg::TAG_NONE;
          end
        end
      end else if (do_disp) begin
        op_q[free_idx]    <= item_i.operation;
        kind_q[free_idx]  <= item_i.kind;
        jr_q[free_idx]    <= item_i.is_jump_register;
        dest_q[free_idx]  <= item_i.dest_tag;
        tag_a_q[free_idx] <= new_tag_a;
        tag_b_q[free_idx] <= new_tag_b;
        val_a_q[free_idx] <= item_i.src1_value;
        val_b_q[free_idx] <= item_i.src2_value;
        imm_q[free_idx]   <= item_i.immediate;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/reservation_station_wakeup_select.sv
// Reservation station top level: input register, slot logic and result register.
//
// Usage: one request channel (req_i) carries broadcast, dispatch, cycle and
// flush beats; each accepted beat produces exactly one response beat on rsp_o.
// A broadcast wakes every waiting operand whose tag matches the bus tag.
// A dispatch beat may place one instruction into the lowest free slot; dispatch
// and cycle beats then issue the lowest-indexed ready slot; a flush empties it.
// Path: a request beat is captured in the input register, passes the slot
// logic and is loaded into the result register once that register can take
// it; the response then stays valid on rsp_o until the receiver takes it.
// Throughput: one beat per cycle while the receiver takes responses; the
// slot update, the free-slot search and the issue select form one short
// combinational pass over eight slots.
// Reset clears all slot valid and ready bits and both pipeline valid bits.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more request; further requests wait on req_i.ready.
`default_nettype none
module reservation_station_wakeup_select (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rsws_in_if.sink     req_i,
  rsws_out_if.source  rsp_o
);

  logic              in_valid_q, in_valid_d;
  rsws_pkg::item_t   in_q;
  logic              out_valid_q, out_valid_d;
  rsws_pkg::result_t out_q, result;
  logic              advance, step, accept;

  assign advance = !out_valid_q || rsp_o.ready;
  assign step    = in_valid_q && advance;
  assign accept  = req_i.valid && req_i.ready;

  assign req_i.ready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.func             <= req_i.func;
      in_q.operation        <= req_i.operation;
      in_q.kind             <= req_i.kind;
      in_q.is_jump_register <= req_i.is_jump_register;
      in_q.dest_tag         <= req_i.dest_tag;
      in_q.src1_tag         <= req_i.src1_tag;
      in_q.src2_tag         <= req_i.src2_tag;
      in_q.src1_value       <= req_i.src1_value;
      in_q.src2_value       <= req_i.src2_value;
      in_q.immediate        <= req_i.immediate;
      in_q.bus_tag          <= req_i.bus_tag;
      in_q.bus_value        <= req_i.bus_value;
    end
    if (step) begin
      out_q <= result;
    end
  end

  rsws_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .result_o (result)
  );

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.issue_valid     = out_q.issue_valid;
  assign rsp_o.issue_operation = out_q.issue_operation;
  assign rsp_o.issue_dest      = out_q.issue_dest;
  assign rsp_o.operand_a       = out_q.operand_a;
  assign rsp_o.operand_b       = out_q.operand_b;
  assign rsp_o.station_full    = out_q.station_full;
  assign rsp_o.error_code      = out_q.error_code;

endmodule
`default_nettype wire

FILE: rtl/rsws_checker.sv
// Port-level checks of the reservation station, bound to the top level.
`default_nettype none
module rsws_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic                         issue_valid_i,
  input wire logic [rsws_pkg::OpW-1:0]     issue_operation_i,
  input wire logic [rsws_pkg::BusTagW-1:0] issue_dest_i,
  input wire logic [rsws_pkg::DataW-1:0]   operand_a_i,
  input wire logic [rsws_pkg::DataW-1:0]   operand_b_i,
  input wire logic                         station_full_i,
  input wire logic [1:0]                   error_code_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response beat dropped while stalled");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !issue_valid_i |-> issue_operation_i == '0 && issue_dest_i == '0
      && operand_a_i == '0 && operand_b_i == '0)
    else $error("issue fields not cleared without an issue");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> error_code_i != 2'd3)
    else $error("undefined error code");

  // A dropped dispatch means the station was full; without an issue it stays full.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i == rsws_pkg::ERR_FULL && !issue_valid_i |-> station_full_i)
    else $error("full drop reported on a station with room");

endmodule

bind reservation_station_wakeup_select rsws_checker u_rsws_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (rsp_o.valid),
  .out_ready_i       (rsp_o.ready),
  .issue_valid_i     (rsp_o.issue_valid),
  .issue_operation_i (rsp_o.issue_operation),
  .issue_dest_i      (rsp_o.issue_dest),
  .operand_a_i       (rsp_o.operand_a),
  .operand_b_i       (rsp_o.operand_b),
  .station_full_i    (rsp_o.station_full),
  .error_code_i      (rsp_o.error_code)
);
`default_nettype wire

FILE: bench/tb_reservation_station_wakeup_select.sv
// Testbench for the reservation station: directed table, random beats, scoreboard.
`default_nettype none
module tb_reservation_station_wakeup_select;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rsws_pkg::KindW-1:0] KIND_R      = 3'd0;
  localparam logic [rsws_pkg::KindW-1:0] KIND_B      = 3'd2;
  localparam logic [rsws_pkg::KindW-1:0] KIND_U      = 3'd3;
  localparam logic [rsws_pkg::KindW-1:0] KIND_J      = 3'd4;
  localparam logic [rsws_pkg::KindW-1:0] KIND_BAD_LO = 3'd5;
  localparam logic [rsws_pkg::KindW-1:0] KIND_BAD_MD = 3'd6;
  localparam logic [rsws_pkg::KindW-1:0] KIND_BAD_HI = 3'd7;
  localparam logic [rsws_pkg::TagW-1:0]  TAG_STUCK   = 6'h3E;
  localparam logic [rsws_pkg::TagW-1:0]  TAG_MIN     = 6'h20;
  localparam int PHASE_BEATS = 375;
  localparam int LONG_HOLD   = 120;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic                          valid;
    logic                          ready;
    logic [rsws_pkg::OpW-1:0]      op;
    logic [rsws_pkg::KindW-1:0]    kind;
    logic                          jr;
    logic [rsws_pkg::BusTagW-1:0]  dest;
    logic [rsws_pkg::TagW-1:0]     tag_a;
    logic [rsws_pkg::TagW-1:0]     tag_b;
    logic [rsws_pkg::DataW-1:0]    val_a;
    logic [rsws_pkg::DataW-1:0]    val_b;
    logic [rsws_pkg::DataW-1:0]    imm;
  } slot_t;

  typedef struct {
    rsws_pkg::item_t   beat;
    bit                pinned;
    rsws_pkg::result_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rsws_in_if  req_if();
  rsws_out_if rsp_if();

  reservation_station_wakeup_select DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  slot_t             rs_slot [rsws_pkg::Entries];
  rsws_pkg::result_t pending_issues [$];
  dir_row_t          dir_rows [$];
  int                mismatch_cnt = 0;
  int                send_idle_pct = 0;
  int                rx_stall_pct = 0;
  int                long_hold_req = 0;
  bit                beat_pinned = 1'b0;
  rsws_pkg::result_t beat_pinned_res = '0;

  // Predicts the response of one accepted beat and updates the station copy.
  function automatic rsws_pkg::result_t advance_station(rsws_pkg::item_t it);
    rsws_pkg::result_t r;
    int                pos;
    bit                issued;
    bit                full;
    r      = '0;
    pos    = -1;
    issued = 1'b0;
    full   = 1'b1;
    case (it.func)
      rsws_pkg::FUNC_BROADCAST: begin
        for (int i = 0; i < rsws_pkg::Entries; i++) begin
          if (rs_slot[i].valid) begin
            if (rs_slot[i].tag_a == {1'b0, it.bus_tag}) begin
              rs_slot[i].val_a = it.bus_value;
              rs_slot[i].tag_a = rsws_pkg::TAG_NONE;
            end
            if (rs_slot[i].tag_b == {1'b0, it.bus_tag}) begin
              rs_slot[i].val_b = it.bus_value;
              rs_slot[i].tag_b = rsws_pkg::TAG_NONE;
            end
            if (rs_slot[i].tag_a == rsws_pkg::TAG_NONE &&
                rs_slot[i].tag_b == rsws_pkg::TAG_NONE) begin
              rs_slot[i].ready = 1'b1;
            end
          end
        end
      end
      rsws_pkg::FUNC_FLUSH: begin
        for (int i = 0; i < rsws_pkg::Entries; i++) rs_slot[i] = '0;
      end
      default: begin
        if (it.func == rsws_pkg::FUNC_DISPATCH) begin
          for (int i = 0; i < rsws_pkg::Entries; i++) begin
            if (!rs_slot[i].valid && pos < 0) pos = i;
          end
          if (pos < 0) begin
            r.error_code = rsws_pkg::ERR_FULL;
          end else if (it.kind > rsws_pkg::KIND_MAX) begin
            r.error_code = rsws_pkg::ERR_KIND;
          end else begin
            rs_slot[pos].valid = 1'b1;
            rs_slot[pos].op    = it.operation;
            rs_slot[pos].kind  = it.kind;
            rs_slot[pos].jr    = it.is_jump_register;
            rs_slot[pos].dest  = it.dest_tag;
            rs_slot[pos].tag_a = it.src1_tag;
            rs_slot[pos].val_a = it.src1_value;
            rs_slot[pos].val_b = it.src2_value;
            rs_slot[pos].imm   = it.immediate;
            // A plain I-type instruction has no second register source.
            rs_slot[pos].tag_b = (it.kind == rsws_pkg::KIND_I && !it.is_jump_register) ?
                                 rsws_pkg::TAG_NONE : it.src2_tag;
            rs_slot[pos].ready = (rs_slot[pos].tag_a == rsws_pkg::TAG_NONE) &&
                                 (rs_slot[pos].tag_b == rsws_pkg::TAG_NONE);
          end
        end
        for (int i = 0; i < rsws_pkg::Entries; i++) begin
          if (!issued && rs_slot[i].valid && rs_slot[i].ready) begin
            issued            = 1'b1;
            r.issue_valid     = 1'b1;
            r.issue_operation = rs_slot[i].op;
            r.issue_dest      = rs_slot[i].dest;
            r.operand_a       = rs_slot[i].val_a;
            r.operand_b       = (rs_slot[i].kind == rsws_pkg::KIND_I && !rs_slot[i].jr) ?
                                rs_slot[i].imm : rs_slot[i].val_b;
            rs_slot[i].valid  = 1'b0;
            rs_slot[i].ready  = 1'b0;
          end
        end
      end
    endcase
    for (int i = 0; i < rsws_pkg::Entries; i++) full &= rs_slot[i].valid;
    r.station_full = full;
    return r;
  endfunction

  function automatic rsws_pkg::item_t mk_disp(logic [rsws_pkg::OpW-1:0] op,
                                              logic [rsws_pkg::KindW-1:0] kind, logic jr,
                                              logic [rsws_pkg::BusTagW-1:0] dest,
                                              logic [rsws_pkg::TagW-1:0] t1,
                                              logic [rsws_pkg::TagW-1:0] t2,
                                              logic [rsws_pkg::DataW-1:0] v1,
                                              logic [rsws_pkg::DataW-1:0] v2,
                                              logic [rsws_pkg::DataW-1:0] imm);
    rsws_pkg::item_t it;
    it                  = '0;
    it.func             = rsws_pkg::FUNC_DISPATCH;
    it.operation        = op;
    it.kind             = kind;
    it.is_jump_register = jr;
    it.dest_tag         = dest;
    it.src1_tag         = t1;
    it.src2_tag         = t2;
    it.src1_value       = v1;
    it.src2_value       = v2;
    it.immediate        = imm;
    return it;
  endfunction

  function automatic rsws_pkg::item_t mk_ctl(logic [1:0] func,
                                             logic [rsws_pkg::BusTagW-1:0] tag,
                                             logic [rsws_pkg::DataW-1:0] val);
    rsws_pkg::item_t it;
    it           = '0;
    it.func      = func;
    it.bus_tag   = tag;
    it.bus_value = val;
    return it;
  endfunction

  function automatic rsws_pkg::result_t mk_res(logic iv, logic [rsws_pkg::OpW-1:0] op,
                                               logic [rsws_pkg::BusTagW-1:0] dest,
                                               logic [rsws_pkg::DataW-1:0] a,
                                               logic [rsws_pkg::DataW-1:0] b, logic full,
                                               logic [1:0] err);
    rsws_pkg::result_t r;
    r.issue_valid     = iv;
    r.issue_operation = op;
    r.issue_dest      = dest;
    r.operand_a       = a;
    r.operand_b       = b;
    r.station_full    = full;
    r.error_code      = err;
    return r;
  endfunction

  function automatic void add_row(rsws_pkg::item_t it, bit pin, rsws_pkg::result_t r);
    dir_row_t row;
    row.beat   = it;
    row.pinned = pin;
    row.res    = r;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [rsws_pkg::TagW-1:0] draw_src_tag();
    int p;
    p = $urandom_range(99);
    if (p < 45) return rsws_pkg::TAG_NONE;
    if (p < 94) return {1'b0, 5'($urandom_range(31))};
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [rsws_pkg::DataW-1:0] draw_word();
    int p;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 16) return '1;
    return $urandom;
  endfunction

  // Random beat; broadcasts mostly carry a tag that some slot is waiting on.
  function automatic rsws_pkg::item_t draw_station_beat();
    rsws_pkg::item_t              it;
    logic [rsws_pkg::BusTagW-1:0] waiting [$];
    int                           p;
    p                   = $urandom_range(99);
    it.func             = (p < 38) ? rsws_pkg::FUNC_BROADCAST :
                          (p < 75) ? rsws_pkg::FUNC_DISPATCH :
                          (p < 97) ? rsws_pkg::FUNC_CYCLE : rsws_pkg::FUNC_FLUSH;
    it.operation        = 6'($urandom_range(63));
    it.kind             = ($urandom_range(99) < 88) ? 3'($urandom_range(rsws_pkg::KIND_MAX)) :
                                                      3'($urandom_range(7));
    it.is_jump_register = ($urandom_range(3) == 0);
    it.dest_tag         = 5'($urandom_range(31));
    it.src1_tag         = draw_src_tag();
    it.src2_tag         = draw_src_tag();
    it.src1_value       = draw_word();
    it.src2_value       = draw_word();
    it.immediate        = draw_word();
    it.bus_tag          = 5'($urandom_range(31));
    it.bus_value        = draw_word();
    for (int i = 0; i < rsws_pkg::Entries; i++) begin
      if (rs_slot[i].valid) begin
        if (!rs_slot[i].tag_a[rsws_pkg::TagW-1]) begin
          waiting.push_back(rs_slot[i].tag_a[rsws_pkg::BusTagW-1:0]);
        end
        if (!rs_slot[i].tag_b[rsws_pkg::TagW-1]) begin
          waiting.push_back(rs_slot[i].tag_b[rsws_pkg::BusTagW-1:0]);
        end
      end
    end
    if (waiting.size() > 0 && $urandom_range(99) < 80) begin
      it.bus_tag = waiting[$urandom_range(waiting.size() - 1)];
    end
    return it;
  endfunction

  function automatic void field_chk(string name, logic [rsws_pkg::DataW-1:0] want,
                                    logic [rsws_pkg::DataW-1:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX) begin
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
    end
  endfunction

  function automatic void check_issue(rsws_pkg::result_t got);
    rsws_pkg::result_t want;
    if (pending_issues.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX) begin
        $display("%0t: response beat with nothing outstanding", $realtime);
      end
      return;
    end
    want = pending_issues.pop_front();
    field_chk("issue_valid", want.issue_valid, got.issue_valid);
    field_chk("issue_operation", want.issue_operation, got.issue_operation);
    field_chk("issue_dest", want.issue_dest, got.issue_dest);
    field_chk("operand_a", want.operand_a, got.operand_a);
    field_chk("operand_b", want.operand_b, got.operand_b);
    field_chk("station_full", want.station_full, got.station_full);
    field_chk("error_code", want.error_code, got.error_code);
  endfunction

  // Both channels are sampled at the rising edge, before any register update.
  always @(posedge clk_i) begin
    rsws_pkg::item_t   seen;
    rsws_pkg::result_t got;
    rsws_pkg::result_t pred;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen.func             = req_if.func;
        seen.operation        = req_if.operation;
        seen.kind             = req_if.kind;
        seen.is_jump_register = req_if.is_jump_register;
        seen.dest_tag         = req_if.dest_tag;
        seen.src1_tag         = req_if.src1_tag;
        seen.src2_tag         = req_if.src2_tag;
        seen.src1_value       = req_if.src1_value;
        seen.src2_value       = req_if.src2_value;
        seen.immediate        = req_if.immediate;
        seen.bus_tag          = req_if.bus_tag;
        seen.bus_value        = req_if.bus_value;
        pred = advance_station(seen);
        pending_issues.push_back(beat_pinned ? beat_pinned_res : pred);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.issue_valid     = rsp_if.issue_valid;
        got.issue_operation = rsp_if.issue_operation;
        got.issue_dest      = rsp_if.issue_dest;
        got.operand_a       = rsp_if.operand_a;
        got.operand_b       = rsp_if.operand_b;
        got.station_full    = rsp_if.station_full;
        got.error_code      = rsp_if.error_code;
        check_issue(got);
      end
    end
  end

  always @(posedge clk_i) begin
    int idle_cycles;
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Response side: random stalls, plus a long hold-off counted here.
  initial begin
    int hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold_req > 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_beat(input rsws_pkg::item_t it, input bit pin,
                           input rsws_pkg::result_t pin_res);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.func             = it.func;
    req_if.operation        = it.operation;
    req_if.kind             = it.kind;
    req_if.is_jump_register = it.is_jump_register;
    req_if.dest_tag         = it.dest_tag;
    req_if.src1_tag         = it.src1_tag;
    req_if.src2_tag         = it.src2_tag;
    req_if.src1_value       = it.src1_value;
    req_if.src2_value       = it.src2_value;
    req_if.immediate        = it.immediate;
    req_if.bus_tag          = it.bus_tag;
    req_if.bus_value        = it.bus_value;
    beat_pinned             = pin;
    beat_pinned_res         = pin_res;
    req_if.valid            = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_issues.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    rsws_pkg::result_t none;
    none = mk_res(1'b0, '0, '0, '0, '0, 1'b0, rsws_pkg::ERR_NONE);
    req_if.valid            = 1'b0;
    req_if.func             = rsws_pkg::FUNC_BROADCAST;
    req_if.operation        = '0;
    req_if.kind             = KIND_R;
    req_if.is_jump_register = 1'b0;
    req_if.dest_tag         = '0;
    req_if.src1_tag         = rsws_pkg::TAG_NONE;
    req_if.src2_tag         = rsws_pkg::TAG_NONE;
    req_if.src1_value       = '0;
    req_if.src2_value       = '0;
    req_if.immediate        = '0;
    req_if.bus_tag          = '0;
    req_if.bus_value        = '0;
    for (int i = 0; i < rsws_pkg::Entries; i++) rs_slot[i] = '0;

    // Empty station, then ready-at-dispatch issue of each operand-b source.
    add_row(mk_ctl(rsws_pkg::FUNC_CYCLE, '0, '0), 1'b1, none);
    add_row(mk_ctl(rsws_pkg::FUNC_BROADCAST, '0, '1), 1'b1, none);
    add_row(mk_disp(6'd63, KIND_R, 1'b0, 5'd31, rsws_pkg::TAG_NONE, rsws_pkg::TAG_NONE,
                    '1, '0, 32'hAAAA_AAAA),
            1'b1, mk_res(1'b1, 6'd63, 5'd31, '1, '0, 1'b0, rsws_pkg::ERR_NONE));
    add_row(mk_disp(6'd0, rsws_pkg::KIND_I, 1'b0, 5'd0, rsws_pkg::TAG_NONE, 6'sd5,
                    '0, 32'h1234_5678, '1),
            1'b1, mk_res(1'b1, 6'd0, 5'd0, '0, '1, 1'b0, rsws_pkg::ERR_NONE));
    add_row(mk_disp(6'd21, rsws_pkg::KIND_I, 1'b1, 5'd17, rsws_pkg::TAG_NONE,
                    rsws_pkg::TAG_NONE, 32'h8000_0000, 32'h5555_5555, 32'h7FFF_FFFF),
            1'b1, mk_res(1'b1, 6'd21, 5'd17, 32'h8000_0000, 32'h5555_5555, 1'b0,
                         rsws_pkg::ERR_NONE));
    add_row(mk_disp(6'd9, KIND_BAD_LO, 1'b0, 5'd1, rsws_pkg::TAG_NONE, rsws_pkg::TAG_NONE,
                    '1, '1, '1),
            1'b1, mk_res(1'b0, '0, '0, '0, '0, 1'b0, rsws_pkg::ERR_KIND));
    add_row(mk_disp(6'd9, KIND_BAD_HI, 1'b1, 5'd2, rsws_pkg::TAG_NONE, rsws_pkg::TAG_NONE,
                    '1, '1, '1),
            1'b1, mk_res(1'b0, '0, '0, '0, '0, 1'b0, rsws_pkg::ERR_KIND));
    // Wakeup: one tag fills both operands; lower slot issues first.
    add_row(mk_disp(6'd12, KIND_B, 1'b0, 5'd4, 6'sd3, 6'sd3, '0, '0, 32'h0000_0FFF),
            1'b0, none);
    add_row(mk_disp(6'd13, KIND_U, 1'b0, 5'd5, 6'sd9, rsws_pkg::TAG_NONE, '0,
                    32'hC001_D00D, '0),
            1'b0, none);
    add_row(mk_ctl(rsws_pkg::FUNC_BROADCAST, 5'd9, 32'hDEAD_BEEF), 1'b0, none);
    add_row(mk_ctl(rsws_pkg::FUNC_BROADCAST, 5'd3, 32'h0F0F_0F0F), 1'b0, none);
    add_row(mk_ctl(rsws_pkg::FUNC_CYCLE, '0, '0), 1'b0, none);
    add_row(mk_ctl(rsws_pkg::FUNC_CYCLE, '0, '0), 1'b0, none);
    // Fill with entries whose negative src1 tags never match, so they stay put.
    for (int i = 0; i < rsws_pkg::Entries; i++) begin
      add_row(mk_disp(6'(i + 40), (i % 2) ? KIND_J : KIND_U, i[0], 5'(i + 20),
                      (i % 2) ? TAG_MIN : TAG_STUCK, 6'sd31, $urandom, $urandom, $urandom),
              1'b0, none);
    end
    // Full is checked before the kind.
    add_row(mk_disp(6'd7, KIND_BAD_MD, 1'b0, 5'd3, rsws_pkg::TAG_NONE, rsws_pkg::TAG_NONE,
                    '0, '0, '0),
            1'b1, mk_res(1'b0, '0, '0, '0, '0, 1'b1, rsws_pkg::ERR_FULL));
    add_row(mk_ctl(rsws_pkg::FUNC_BROADCAST, 5'd31, '1), 1'b1,
            mk_res(1'b0, '0, '0, '0, '0, 1'b1, rsws_pkg::ERR_NONE));
    add_row(mk_ctl(rsws_pkg::FUNC_CYCLE, '0, '0), 1'b1,
            mk_res(1'b0, '0, '0, '0, '0, 1'b1, rsws_pkg::ERR_NONE));
    add_row(mk_ctl(rsws_pkg::FUNC_FLUSH, '0, '0), 1'b1, none);

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].res);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; rx_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin send_idle_pct = 6;  rx_stall_pct = 6;  end
      endcase
      // The receiver holds off while beats keep coming, so the input backs up.
      if (phase == 0) long_hold_req = LONG_HOLD;
      repeat (PHASE_BEATS) send_beat(draw_station_beat(), 1'b0, none);
      req_if.valid = 1'b0;
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_issues.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
